>>> rtl/matrix3x3_inverse_assert.svh
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define M3INV_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("m3inv check failed");

// Next-cycle implication, reset included.
`define M3INV_ASSERT_NEXT(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("m3inv check failed");

`endif

>>> rtl/m3inv_pkg.sv
package m3inv_pkg;

  localparam int ElemW  = 16;
  localparam int ProdW  = 2 * ElemW;
  localparam int CofW   = ProdW + 1;
  localparam int DprodW = ElemW + CofW;
  localparam int DetW   = DprodW + 2;
  localparam int DmagW  = DprodW - 1;
  localparam int OutW   = 32;
  localparam int ThrW   = 20;
  localparam int FracIn = 8;
  localparam int QBits  = 32;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(2);

  typedef logic signed [ElemW-1:0]  elem_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CofW-1:0]   cof_t;
  typedef logic signed [DprodW-1:0] dprod_t;
  typedef logic signed [DetW-1:0]   det_t;
  typedef logic [DmagW-1:0]         dmag_t;
  typedef logic [QBits-1:0]         quo_t;
  typedef logic [FracIn-1:0]        lowb_t;

  // Operand pairs for the eighteen products; cofactor j is prod[2j] - prod[2j+1].
  localparam logic [3:0] MulA [18] = '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2,
                                       4'd5, 4'd3, 4'd0, 4'd2, 4'd2, 4'd0,
                                       4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] MulB [18] = '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4,
                                       4'd6, 4'd8, 4'd8, 4'd6, 4'd3, 4'd5,
                                       4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

endpackage

>>> rtl/matrix3x3_inverse.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid / in_ready    | elem_r0c0 .. elem_r2c2
// out     | output    | out_valid / out_ready  | inv_r0c0 .. inv_r2c2, singular
// cfg     | input     | cfg_valid / cfg_ready  | cfg_data (singular threshold)
// One matrix enters per cycle while the output word is not held.
// The pipeline is five front stages, the operand stage, 32 divider stages and the output register.
// Reset clears all valid bits and loads the threshold with 2; cfg_ready is always high.
// When the output word is held, the whole pipeline holds and in_ready falls.
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse
  import m3inv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ElemW-1:0] elem_r0c0,
  input  logic signed [ElemW-1:0] elem_r0c1,
  input  logic signed [ElemW-1:0] elem_r0c2,
  input  logic signed [ElemW-1:0] elem_r1c0,
  input  logic signed [ElemW-1:0] elem_r1c1,
  input  logic signed [ElemW-1:0] elem_r1c2,
  input  logic signed [ElemW-1:0] elem_r2c0,
  input  logic signed [ElemW-1:0] elem_r2c1,
  input  logic signed [ElemW-1:0] elem_r2c2,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OutW-1:0]  inv_r0c0,
  output logic signed [OutW-1:0]  inv_r0c1,
  output logic signed [OutW-1:0]  inv_r0c2,
  output logic signed [OutW-1:0]  inv_r1c0,
  output logic signed [OutW-1:0]  inv_r1c1,
  output logic signed [OutW-1:0]  inv_r1c2,
  output logic signed [OutW-1:0]  inv_r2c0,
  output logic signed [OutW-1:0]  inv_r2c1,
  output logic signed [OutW-1:0]  inv_r2c2,
  output logic                    singular,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ThrW-1:0]         cfg_data
);

  logic            adv;
  logic [ThrW-1:0] thr;
  elem_t           in_e [9];

  // Front stages.
  logic  v1, v2, v3, v4, v5;
  elem_t e1 [9];
  elem_t e2 [3];
  elem_t e3 [3];
  prod_t p2 [18];
  cof_t  c3 [9];
  cof_t  c4 [9];
  cof_t  c5 [9];
  dprod_t dp4 [3];
  det_t  det5;

  // Divider stages: index 0 is the prepared operand, index s after s steps.
  logic  dv   [QBits+1];
  logic  dsng [QBits+1];
  dmag_t dmag [QBits+1];
  logic  dneg [QBits+1][9];
  logic  dovf [QBits+1][9];
  lowb_t dlow [QBits+1][9];
  dmag_t drem [QBits+1][9];
  quo_t  dq   [QBits+1][9];

  logic                  ov;
  logic                  osng;
  logic signed [OutW-1:0] oinv [9];

  assign adv       = !ov || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  assign in_e[0] = elem_r0c0;
  assign in_e[1] = elem_r0c1;
  assign in_e[2] = elem_r0c2;
  assign in_e[3] = elem_r1c0;
  assign in_e[4] = elem_r1c1;
  assign in_e[5] = elem_r1c2;
  assign in_e[6] = elem_r2c0;
  assign in_e[7] = elem_r2c1;
  assign in_e[8] = elem_r2c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ThrReset;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      dv[0] <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dv[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        e1[i] <= in_e[i];
      end
      for (int i = 0; i < 18; i++) begin
        p2[i] <= e1[MulA[i]] * e1[MulB[i]];
      end
      for (int i = 0; i < 3; i++) begin
        e2[i] <= e1[i];
        e3[i] <= e2[i];
      end
      for (int j = 0; j < 9; j++) begin
        c3[j] <= CofW'(p2[2*j]) - CofW'(p2[2*j+1]);
        c4[j] <= c3[j];
        c5[j] <= c4[j];
      end
      // Row 0 expansion of the determinant.
      for (int i = 0; i < 3; i++) begin
        dp4[i] <= DprodW'(e3[i]) * DprodW'(c3[3*i]);
      end
      det5 <= DetW'(dp4[0]) + DetW'(dp4[1]) + DetW'(dp4[2]);
    end
  end

  // Operand preparation: magnitudes, signs and the overflow test.
  logic           det_neg;
  dmag_t          det_mag;
  logic [CofW-2:0] cmag [9];

  always_comb begin
    det_neg = det5[DetW-1];
    det_mag = DmagW'(det_neg ? -det5 : det5);
    for (int j = 0; j < 9; j++) begin
      cmag[j] = (CofW-1)'(c5[j][CofW-1] ? -c5[j] : c5[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag[0] <= det_mag;
      dsng[0] <= (det_mag == '0) || (det_mag < DmagW'(thr));
      for (int j = 0; j < 9; j++) begin
        dneg[0][j] <= c5[j][CofW-1] ^ det_neg;
        // The quotient cannot fit 32 bits when |cof| >= |det| * 2^8.
        dovf[0][j] <= {{(DmagW+FracIn-CofW+1){1'b0}}, cmag[j]} >= {det_mag, {FracIn{1'b0}}};
        dlow[0][j] <= cmag[j][FracIn-1:0];
        drem[0][j] <= DmagW'(cmag[j][CofW-2:FracIn]);
        dq[0][j]   <= '0;
      end
    end
  end

  for (genvar s = 0; s < QBits; s++) begin : g_div
    logic [DmagW+1:0] trial [9];
    logic             nbit  [9];

    always_comb begin
      for (int j = 0; j < 9; j++) begin
        nbit[j]  = (s < FracIn) ? dlow[s][j][(FracIn-1-s) % FracIn] : 1'b0;
        trial[j] = {1'b0, drem[s][j], nbit[j]} - {2'b00, dmag[s]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (adv) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dmag[s+1] <= dmag[s];
        dsng[s+1] <= dsng[s];
        for (int j = 0; j < 9; j++) begin
          dneg[s+1][j] <= dneg[s][j];
          dovf[s+1][j] <= dovf[s][j];
          dlow[s+1][j] <= dlow[s][j];
          if (!trial[j][DmagW+1]) begin
            drem[s+1][j] <= trial[j][DmagW-1:0];
          end else begin
            drem[s+1][j] <= {drem[s][j][DmagW-2:0], nbit[j]};
          end
          dq[s+1][j] <= {dq[s][j][QBits-2:0], !trial[j][DmagW+1]};
        end
      end
    end
  end

  // Saturation, sign and the singular override.
  quo_t lim [9];
  quo_t qs  [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      lim[j] = dneg[QBits][j] ? {1'b1, {(QBits-1){1'b0}}} : {1'b0, {(QBits-1){1'b1}}};
      qs[j]  = (dovf[QBits][j] || dq[QBits][j] > lim[j]) ? lim[j] : dq[QBits][j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= dv[QBits];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      osng <= dsng[QBits];
      for (int j = 0; j < 9; j++) begin
        if (dsng[QBits]) begin
          oinv[j] <= '0;
        end else begin
          oinv[j] <= dneg[QBits][j] ? -qs[j] : qs[j];
        end
      end
    end
  end

  assign out_valid = ov;
  assign singular  = osng;
  assign inv_r0c0  = oinv[0];
  assign inv_r0c1  = oinv[1];
  assign inv_r0c2  = oinv[2];
  assign inv_r1c0  = oinv[3];
  assign inv_r1c1  = oinv[4];
  assign inv_r1c2  = oinv[5];
  assign inv_r2c0  = oinv[6];
  assign inv_r2c1  = oinv[7];
  assign inv_r2c2  = oinv[8];

  `M3INV_ASSERT_IMPLY(a_sing_zero, clk, rst, out_valid && singular,
    inv_r0c0 == '0 && inv_r1c1 == '0 && inv_r2c2 == '0 && inv_r0c2 == '0)
  `M3INV_ASSERT_IMPLY(a_ready_rule, clk, rst, 1'b1, in_ready == (!out_valid || out_ready))
  `M3INV_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid && !v1 && !dv[0])
  `M3INV_ASSERT_NEXT(a_hold_pipe, clk, !rst && out_valid && !out_ready,
    $stable(dv[QBits]) && $stable(v5))

endmodule
